/* rtl/frd_pkg.sv */
// Package for the FastCGI record deframer: phase codes, result and status types.
// No dependencies; used by the parser, the top level and the bench.
`timescale 1ns / 1ps

package frd_pkg;

  // Header bytes: version, type, request id hi/lo, length hi/lo, padding, reserved
  localparam int unsigned HdrBytes   = 8;
  localparam int unsigned HdrIdxW    = $clog2(HdrBytes);

  localparam logic [HdrIdxW-1:0] HdrIdxType   = HdrIdxW'(1);
  localparam logic [HdrIdxW-1:0] HdrIdxLenHi  = HdrIdxW'(4);
  localparam logic [HdrIdxW-1:0] HdrIdxLenLo  = HdrIdxW'(5);
  localparam logic [HdrIdxW-1:0] HdrIdxPad    = HdrIdxW'(6);
  localparam logic [HdrIdxW-1:0] HdrIdxRsvd   = HdrIdxW'(7);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_CONTENT = 2'd1,
    PH_PADDING = 2'd2
  } frd_phase_e;

  // One result item
  typedef struct packed {
    logic [7:0] record_type;
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       last_of_record;
  } frd_result_t;

  // Parser status seen by the top level
  typedef struct packed {
    frd_phase_e phase;
    logic       content_zero;
  } frd_status_t;

endpackage

/* rtl/frd_if.sv */
// Valid/ready channel interfaces for the FastCGI record deframer.
// Standalone; the payload matches the fields carried by frd_pkg::frd_result_t.
`timescale 1ns / 1ps

interface frd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface frd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] record_type;
  logic [7:0] payload_byte;
  logic       has_byte;
  logic       last_of_record;

  modport source (output valid, output record_type, output payload_byte,
                  output has_byte, output last_of_record, input ready);
  modport sink   (input valid, input record_type, input payload_byte,
                  input has_byte, input last_of_record, output ready);
endinterface

/* rtl/fastcgi_record_deframer.sv */
// FastCGI record deframer: splits a byte stream into typed content bytes.
// Depends on frd_pkg, frd_in_if, frd_out_if and frd_parser.
//
// Usage:
//   stream_i carries raw stream bytes, one per transfer. Each 8-byte record
//   header is taken silently; every content byte then leaves on result_o
//   tagged with the record type, the final one with last_of_record set.
//   Padding bytes are dropped. A record with no content gives one result
//   with has_byte low and last_of_record high when its reserved byte arrives.
// Timing:
//   One byte per cycle sustained while result_o is ready. A byte is held in
//   the input register, and the parser step then loads the result register,
//   from which the result is offered on result_o.
// Reset:
//   rst_ni (async, active low) empties both registers and returns the
//   parser to the start of a header.
// Stall:
//   While result_o is held off, the input register keeps one byte and then
//   stream_i.ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps

module fastcgi_record_deframer (
  input  logic      clk_i,
  input  logic      rst_ni,
  frd_in_if.sink    stream_i,
  frd_out_if.source result_o
);
  import frd_pkg::*;

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        out_vld_q, out_vld_d;
  frd_result_t out_q;
  logic        step;
  logic        res_vld;
  frd_result_t res;
  frd_status_t status;

  // Parser steps when its result has room to go
  assign step           = in_vld_q && (!out_vld_q || result_o.ready);
  assign stream_i.ready = !in_vld_q || step;

  frd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .res_vld_o(res_vld),
    .res_o    (res),
    .status_o (status)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (stream_i.ready) begin
      in_vld_q <= stream_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stream_i.ready && stream_i.valid) begin
      in_byte_q <= stream_i.stream_byte;
    end
  end

  // Result register
  always_comb begin
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = res_vld;
    end else if (result_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_vld) begin
      out_q <= res;
    end
  end

  assign result_o.valid          = out_vld_q;
  assign result_o.record_type    = out_q.record_type;
  assign result_o.payload_byte   = out_q.payload_byte;
  assign result_o.has_byte       = out_q.has_byte;
  assign result_o.last_of_record = out_q.last_of_record;

  // An empty notice is always the end of its record and carries a zero byte
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.has_byte) |-> (out_q.last_of_record && out_q.payload_byte == 8'd0))
    else $error("empty record notice not marked last");

  // The content phase never runs with no bytes left
  a_content_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.phase == PH_CONTENT) |-> !status.content_zero)
    else $error("content phase with zero bytes left");

  // A held byte is only kept back by a stalled full result register
  a_hold_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !stream_i.ready) |-> (out_vld_q && !result_o.ready))
    else $error("input held without output stall");

  // A result never appears without a parser step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_vld_q && !step) |=> !out_vld_q)
    else $error("result appeared without a parser step");

endmodule

/* rtl/frd_parser.sv */
// Record header parser and content counter of the FastCGI record deframer.
// Depends on frd_pkg. Advances one byte per step_i pulse.
`timescale 1ns / 1ps

module frd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output logic                res_vld_o,
  output frd_pkg::frd_result_t res_o,
  output frd_pkg::frd_status_t status_o
);
  import frd_pkg::*;

  frd_phase_e          phase_q, phase_d;
  logic [HdrIdxW-1:0]  idx_q, idx_d;
  logic [7:0]          type_q, type_d;
  logic [7:0]          len_hi_q, len_hi_d;
  logic [15:0]         content_q, content_d;
  logic [7:0]          pad_q, pad_d;

  // Next state
  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    type_d    = type_q;
    len_hi_d  = len_hi_q;
    content_d = content_q;
    pad_d     = pad_q;
    case (phase_q)
      PH_CONTENT: begin
        content_d = content_q - 16'd1;
        if (content_q == 16'd1) begin
          phase_d = (pad_q != 8'd0) ? PH_PADDING : PH_HEADER;
          idx_d   = '0;
        end
      end
      PH_PADDING: begin
        pad_d = pad_q - 8'd1;
        if (pad_q == 8'd1) begin
          phase_d = PH_HEADER;
          idx_d   = '0;
        end
      end
      default: begin
        phase_d = PH_HEADER;
        // index wraps to zero after the reserved byte
        idx_d   = idx_q + HdrIdxW'(1);
        case (idx_q)
          HdrIdxType:  type_d    = byte_i;
          HdrIdxLenHi: len_hi_d  = byte_i;
          HdrIdxLenLo: content_d = {len_hi_q, byte_i};
          HdrIdxPad:   pad_d     = byte_i;
          HdrIdxRsvd: begin
            if (content_q == 16'd0) begin
              phase_d = (pad_q != 8'd0) ? PH_PADDING : PH_HEADER;
            end else begin
              phase_d = PH_CONTENT;
            end
          end
          default: ;
        endcase
      end
    endcase
  end

  // Result of the current byte
  always_comb begin
    res_vld_o            = 1'b0;
    res_o.record_type    = type_q;
    res_o.payload_byte   = 8'd0;
    res_o.has_byte       = 1'b0;
    res_o.last_of_record = 1'b1;
    case (phase_q)
      PH_CONTENT: begin
        res_vld_o            = 1'b1;
        res_o.payload_byte   = byte_i;
        res_o.has_byte       = 1'b1;
        res_o.last_of_record = (content_q == 16'd1);
      end
      PH_PADDING: ;
      default: begin
        // empty record notice on the reserved byte
        res_vld_o = (idx_q == HdrIdxRsvd) && (content_q == 16'd0);
      end
    endcase
  end

  assign status_o.phase        = phase_q;
  assign status_o.content_zero = (content_q == 16'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      idx_q     <= '0;
      type_q    <= 8'd0;
      len_hi_q  <= 8'd0;
      content_q <= 16'd0;
      pad_q     <= 8'd0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      type_q    <= type_d;
      len_hi_q  <= len_hi_d;
      content_q <= content_d;
      pad_q     <= pad_d;
    end
  end

endmodule

/* bench/tb.sv */
// Self-checking bench for fastcgi_record_deframer: directed header/content rows, then random
// records, scored against an in-bench parser model or, for typed rows, a written expectation.
// Depends on frd_pkg, frd_in_if, frd_out_if and the deframer RTL.
`timescale 1ns / 1ps

module tb;
  import frd_pkg::*;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned RandomBytes = 750;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned MaxReports  = 10;
  localparam frd_result_t NoResult    = '0;

  // One directed row; when typed is set the expectation is written out here
  typedef struct {
    logic [7:0]  stream_byte;
    bit          typed;
    bit          gives;
    frd_result_t want;
  } stim_row_t;

  localparam int unsigned DirRows = 19;

  logic clk_i = 1'b0;
  logic rst_ni;

  frd_in_if  stream_if ();
  frd_out_if result_if ();

  fastcgi_record_deframer dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stream_i (stream_if),
    .result_o (result_if)
  );

  always #2 clk_i = ~clk_i;

  // Parser model state
  frd_phase_e          model_phase;
  logic [HdrIdxW-1:0]  model_hdr_idx;
  logic [7:0]          model_type;
  logic [7:0]          model_len_hi;
  logic [15:0]         model_content_left;
  logic [7:0]          model_pad_left;

  frd_result_t pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned quiet_cycles   = 0;
  bit          idle_enable    = 1'b1;

  // Empty record, zero padding: header only, notice on the reserved byte
  // Then type FF, two content bytes, one padding byte
  stim_row_t dir_rows [DirRows] = '{
    '{8'h01, 1'b1, 1'b0, NoResult},
    '{8'h0A, 1'b1, 1'b0, NoResult},
    '{8'h00, 1'b1, 1'b0, NoResult},
    '{8'h01, 1'b1, 1'b0, NoResult},
    '{8'h00, 1'b1, 1'b0, NoResult},
    '{8'h00, 1'b1, 1'b0, NoResult},
    '{8'h00, 1'b1, 1'b0, NoResult},
    '{8'h00, 1'b1, 1'b1, '{record_type: 8'h0A, payload_byte: 8'h00,
                          has_byte: 1'b0, last_of_record: 1'b1}},
    '{8'hFF, 1'b1, 1'b0, NoResult},
    '{8'hFF, 1'b1, 1'b0, NoResult},
    '{8'hFF, 1'b1, 1'b0, NoResult},
    '{8'hFF, 1'b1, 1'b0, NoResult},
    '{8'h00, 1'b1, 1'b0, NoResult},
    '{8'h02, 1'b1, 1'b0, NoResult},
    '{8'h01, 1'b1, 1'b0, NoResult},
    '{8'hFF, 1'b1, 1'b0, NoResult},
    '{8'h5A, 1'b0, 1'b0, NoResult},
    '{8'hFF, 1'b1, 1'b1, '{record_type: 8'hFF, payload_byte: 8'hFF,
                          has_byte: 1'b1, last_of_record: 1'b1}},
    '{8'h80, 1'b0, 1'b0, NoResult}
  };

  function automatic void model_end_content();
    model_phase   = (model_pad_left != 8'd0) ? PH_PADDING : PH_HEADER;
    model_hdr_idx = '0;
  endfunction

  // Advance the parser model by one stream byte; returns 1 when a result comes out
  function automatic bit deframe_byte(input logic [7:0] b, output frd_result_t res);
    res = '0;
    if (model_phase == PH_CONTENT) begin
      model_content_left = model_content_left - 16'd1;
      res.record_type    = model_type;
      res.payload_byte   = b;
      res.has_byte       = 1'b1;
      res.last_of_record = (model_content_left == 16'd0);
      if (model_content_left == 16'd0) model_end_content();
      return 1'b1;
    end
    if (model_phase == PH_PADDING) begin
      model_pad_left = model_pad_left - 8'd1;
      if (model_pad_left == 8'd0) begin
        model_phase   = PH_HEADER;
        model_hdr_idx = '0;
      end
      return 1'b0;
    end
    // header, and the unused phase code
    model_phase = PH_HEADER;
    case (model_hdr_idx)
      HdrIdxType:  model_type = b;
      HdrIdxLenHi: model_len_hi = b;
      HdrIdxLenLo: model_content_left = {model_len_hi, b};
      HdrIdxPad:   model_pad_left = b;
      HdrIdxRsvd: begin
        if (model_content_left == 16'd0) begin
          res.record_type    = model_type;
          res.last_of_record = 1'b1;
          model_end_content();
          return 1'b1;
        end
        model_phase   = PH_CONTENT;
        model_hdr_idx = '0;
        return 1'b0;
      end
      default: ;
    endcase
    model_hdr_idx = model_hdr_idx + 1'b1;
    return 1'b0;
  endfunction

  // Offer one byte, wait for its transfer, queue what it should produce
  task automatic push_byte(input logic [7:0] b, input bit typed, input bit gives,
                           input frd_result_t want);
    frd_result_t got;
    bit          made;
    while (idle_enable && $urandom_range(99) < 35) begin
      stream_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    stream_if.valid       <= 1'b1;
    stream_if.stream_byte <= b;
    do @(posedge clk_i); while (!stream_if.ready);
    bytes_sent++;
    made = deframe_byte(b, got);
    if (typed) begin
      made = gives;
      got  = want;
    end
    if (made) pending_results.push_back(got);
  endtask

  // Whole record: header with random id fields, random content and padding
  task automatic push_record(input logic [15:0] len, input logic [7:0] pad);
    push_byte(8'($urandom_range(255)), 1'b0, 1'b0, NoResult);
    push_byte(8'($urandom_range(255)), 1'b0, 1'b0, NoResult);
    push_byte(8'($urandom_range(255)), 1'b0, 1'b0, NoResult);
    push_byte(8'($urandom_range(255)), 1'b0, 1'b0, NoResult);
    push_byte(len[15:8], 1'b0, 1'b0, NoResult);
    push_byte(len[7:0], 1'b0, 1'b0, NoResult);
    push_byte(pad, 1'b0, 1'b0, NoResult);
    push_byte(8'($urandom_range(255)), 1'b0, 1'b0, NoResult);
    for (int unsigned i = 0; i < len + pad; i++)
      push_byte(8'($urandom_range(255)), 1'b0, 1'b0, NoResult);
  endtask

  // Result side backpressure
  always @(posedge clk_i)
    result_if.ready <= !idle_enable || ($urandom_range(99) >= 35);

  // Score each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    frd_result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("unexpected result: type %h byte %h has %b last %b",
                   result_if.record_type, result_if.payload_byte,
                   result_if.has_byte, result_if.last_of_record);
      end else begin
        want = pending_results.pop_front();
        if (want.record_type    !== result_if.record_type  ||
            want.payload_byte   !== result_if.payload_byte ||
            want.has_byte       !== result_if.has_byte     ||
            want.last_of_record !== result_if.last_of_record) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("mismatch: exp type %h byte %h has %b last %b, got %h %h %b %b",
                     want.record_type, want.payload_byte, want.has_byte,
                     want.last_of_record, result_if.record_type,
                     result_if.payload_byte, result_if.has_byte,
                     result_if.last_of_record);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [15:0] len;
    logic [7:0]  pad;
    int unsigned rec;
    int unsigned sel;

    rst_ni                = 1'b0;
    stream_if.valid       = 1'b0;
    stream_if.stream_byte = 8'h00;
    result_if.ready       = 1'b0;
    model_phase           = PH_HEADER;
    model_hdr_idx         = '0;
    model_type            = 8'h00;
    model_len_hi          = 8'h00;
    model_content_left    = 16'h0000;
    model_pad_left        = 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < DirRows; i++)
      push_byte(dir_rows[i].stream_byte, dir_rows[i].typed, dir_rows[i].gives,
                dir_rows[i].want);

    // Random records; record 3 carries a long length and record 5 the full padding
    rec = 0;
    while (bytes_sent < DirRows + RandomBytes) begin
      sel = $urandom_range(99);
      if (sel < 20)      len = 16'd0;
      else if (sel < 85) len = 16'($urandom_range(1, 16));
      else               len = 16'($urandom_range(17, 64));
      pad = ($urandom_range(99) < 40) ? 8'd0 : 8'($urandom_range(1, 8));
      if (rec == 3) len = 16'h0100 + 16'($urandom_range(0, 40));
      if (rec == 5) pad = 8'hFF;
      // hold the stream until the output side has caught up
      if (rec == 2) begin
        stream_if.valid <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      idle_enable = !(rec >= 6 && rec < 16);
      push_record(len, pad);
      rec++;
    end
    stream_if.valid <= 1'b0;
    idle_enable = 1'b1;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
